[hdl/fft_magnitude_spectrum_unit_macros.svh]
// ----------------------------------------------------------------------------
// FFT magnitude spectrum unit: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FFT_MAGNITUDE_SPECTRUM_UNIT_MACROS_SVH
`define FFT_MAGNITUDE_SPECTRUM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/fmsu_pkg.sv]
// ----------------------------------------------------------------------------
// FFT magnitude spectrum unit: shared package
// Command codes, control structs and the twiddle generator.
// ----------------------------------------------------------------------------
package fmsu_pkg;

  // Width of the configuration register.
  localparam int unsigned CFG_BITS = 4;

  // Command codes of an input beat.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Butterfly datapath strobes.
  typedef struct packed {
    logic ld_u;
    logic mul;
    logic rnd;
  } bfly_ctl_t;

  // Magnitude unit strobes and status.
  typedef struct packed {
    logic sq;
    logic start;
  } mag_ctl_t;

  typedef struct packed {
    logic done;
  } mag_sts_t;

  // Quarter-wave twiddle value, rounded half up and saturated below +1.0.
  // Evaluated at elaboration only.
  function automatic int twiddle_q(int unsigned t, int unsigned log2_max,
                                   int unsigned tw_bits, bit use_sin);
    real ang;
    real v;
    real full;
    int  q;
    int  lim;
    ang  = 6.283185307179586 * real'(t) * (2.0 ** (-real'(log2_max)));
    full = 2.0 ** real'(tw_bits - 1);
    lim  = (1 << (tw_bits - 1)) - 1;
    v    = use_sin ? $sin(ang) : $cos(ang);
    q    = $rtoi(v * full + 0.5);
    if (q < 0) q = 0;
    if (q > lim) q = lim;
    return q;
  endfunction

endpackage

[hdl/fmsu_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fmsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fmsu_bfly.sv]
// ----------------------------------------------------------------------------
// FFT magnitude spectrum unit: butterfly datapath
// Holds the top operand, forms the twiddle product with rounding and
// produces the saturated sum and difference.
// ----------------------------------------------------------------------------
module fmsu_bfly #(
  parameter int unsigned W_BITS  = 27,
  parameter int unsigned TW_BITS = 16
) (
  input  logic                       clk_i,
  input  fmsu_pkg::bfly_ctl_t        ctl_i,
  input  logic [2*W_BITS-1:0]        rdata_i,
  input  logic signed [TW_BITS-1:0]  tw_c_i,
  input  logic signed [TW_BITS-1:0]  tw_s_i,
  output logic [2*W_BITS-1:0]        sum_a_o,
  output logic [2*W_BITS-1:0]        sum_b_o
);

  import fmsu_pkg::*;

  localparam int unsigned TF = TW_BITS - 1;
  localparam int unsigned PW = W_BITS + TW_BITS;
  localparam int unsigned VW = PW + 1 - TF;

  logic signed [W_BITS-1:0] ur_q, ui_q;
  logic signed [W_BITS-1:0] br, bi;
  logic signed [PW-1:0]     p1_q, p2_q, p3_q, p4_q;
  logic signed [PW:0]       sr, si;
  logic signed [VW-1:0]     vr_q, vi_q;
  logic signed [VW:0]       s_ar, s_ai, s_br, s_bi;

  localparam logic signed [PW:0] RND = (PW+1)'(1) << (TF - 1);

  // Saturate a grown sum into the work width.
  function automatic logic [W_BITS-1:0] sat_w(logic signed [VW:0] x);
    logic [VW-W_BITS+1:0] top;
    top = x[VW:W_BITS-1];
    if (top == '0 || top == '1) begin
      return x[W_BITS-1:0];
    end
    return x[VW] ? {1'b1, {(W_BITS-1){1'b0}}} : {1'b0, {(W_BITS-1){1'b1}}};
  endfunction

  assign br = rdata_i[2*W_BITS-1:W_BITS];
  assign bi = rdata_i[W_BITS-1:0];

  // Rounded product sums, half up after the fraction shift.
  assign sr = (PW+1)'(p1_q) + (PW+1)'(p2_q) + RND;
  assign si = (PW+1)'(p3_q) - (PW+1)'(p4_q) + RND;

  // Pipeline of the top operand, the products and the rounded terms.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_u) begin
      ur_q <= rdata_i[2*W_BITS-1:W_BITS];
      ui_q <= rdata_i[W_BITS-1:0];
    end
    if (ctl_i.mul) begin
      p1_q <= br * tw_c_i;
      p2_q <= bi * tw_s_i;
      p3_q <= bi * tw_c_i;
      p4_q <= br * tw_s_i;
    end
    if (ctl_i.rnd) begin
      vr_q <= VW'(sr >>> TF);
      vi_q <= VW'(si >>> TF);
    end
  end

  // Sum and difference with saturation.
  assign s_ar = (VW+1)'(ur_q) + (VW+1)'(vr_q);
  assign s_ai = (VW+1)'(ui_q) + (VW+1)'(vi_q);
  assign s_br = (VW+1)'(ur_q) - (VW+1)'(vr_q);
  assign s_bi = (VW+1)'(ui_q) - (VW+1)'(vi_q);

  assign sum_a_o = {sat_w(s_ar), sat_w(s_ai)};
  assign sum_b_o = {sat_w(s_br), sat_w(s_bi)};

endmodule

[hdl/fmsu_mag.sv]
// ----------------------------------------------------------------------------
// FFT magnitude spectrum unit: magnitude unit
// Squares both parts of a work word, then takes the floor square root
// of their sum one result bit per cycle.
// ----------------------------------------------------------------------------
module fmsu_mag #(
  parameter int unsigned W_BITS = 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmsu_pkg::mag_ctl_t   ctl_i,
  input  logic [2*W_BITS-1:0]  data_i,
  output fmsu_pkg::mag_sts_t   sts_o,
  output logic [W_BITS-2:0]    mag_o
);

  import fmsu_pkg::*;

  localparam int unsigned CW = $clog2(W_BITS + 1);

  logic signed [W_BITS-1:0] re, im;
  logic [W_BITS-1:0]        ar, ai;
  logic [2*W_BITS-1:0]      sqr_q, sqi_q, x_q;
  logic [W_BITS+1:0]        rem_q;
  logic [W_BITS-1:0]        root_q;
  logic [W_BITS+3:0]        rem_n, trial;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]            cnt_q, cnt_d;

  // Absolute values; the most negative value maps to its unsigned magnitude.
  assign re = data_i[2*W_BITS-1:W_BITS];
  assign im = data_i[W_BITS-1:0];
  assign ar = re[W_BITS-1] ? W_BITS'(-re) : W_BITS'(re);
  assign ai = im[W_BITS-1] ? W_BITS'(-im) : W_BITS'(im);

  // One restoring step: bring down two bits, try root*4+1.
  assign rem_n = {rem_q, x_q[2*W_BITS-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W_BITS);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Squares, operand and partial root.
  always_ff @(posedge clk_i) begin
    if (ctl_i.sq) begin
      sqr_q <= (2*W_BITS)'(ar) * (2*W_BITS)'(ar);
      sqi_q <= (2*W_BITS)'(ai) * (2*W_BITS)'(ai);
    end
    if (ctl_i.start) begin
      x_q    <= sqr_q + sqi_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q <= x_q << 2;
      if (rem_n >= trial) begin
        rem_q  <= (W_BITS+2)'(rem_n - trial);
        root_q <= {root_q[W_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n[W_BITS+1:0];
        root_q <= {root_q[W_BITS-2:0], 1'b0};
      end
    end
  end

  assign sts_o.done = done_q;
  assign mag_o      = root_q[W_BITS-1] ? '1 : root_q[W_BITS-2:0];

endmodule

[hdl/fft_magnitude_spectrum_unit.sv]
// ----------------------------------------------------------------------------
// FFT magnitude spectrum unit
// Loads real samples, runs a radix-2 decimation-in-time FFT in place and
// serves the magnitudes of bins 0..N/2.
// ----------------------------------------------------------------------------
// A load beat writes the sample straight into the work memory at its
// bit-reversed address. A read beat passes through the RDOUT state and waits
// there for the result register to be free. The load beat that completes a
// block of N samples starts the transform, during which no beat is accepted:
// a first read of the work memory, then N/2*log2(N) butterflies, each through
// the states RB, MUL, RND, WA and WB, paced by the single read and single
// write port of the work memory, and then N/2+1 magnitudes, each read,
// squared and taken through the bit-serial square root, which yields W bits
// (W = SAMPLE_BITS+LOG2_MAX_POINTS+1). The magnitude store reads as zero after
// reset and above the last transform's half length, without a clearing pass.
// ----------------------------------------------------------------------------
`include "fft_magnitude_spectrum_unit_macros.svh"

module fft_magnitude_spectrum_unit #(
  parameter int unsigned LOG2_MAX_POINTS = 10,
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned TWIDDLE_BITS    = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fmsu_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   command_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic [LOG2_MAX_POINTS-1:0]             bin_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [LOG2_MAX_POINTS-1:0]             read_index_o,
  output logic [SAMPLE_BITS+LOG2_MAX_POINTS-1:0] magnitude_o,
  output logic                                   index_error_o
);

  import fmsu_pkg::*;

  localparam int unsigned L          = LOG2_MAX_POINTS;
  localparam int unsigned MAX_POINTS = 1 << L;
  localparam int unsigned HALF_MAX   = MAX_POINTS / 2;
  localparam int unsigned QUARTER    = MAX_POINTS / 4;
  localparam int unsigned W          = SAMPLE_BITS + L + 1;
  localparam int unsigned MAG_BITS   = W - 1;
  localparam int unsigned SW         = $clog2(L + 1);
  localparam int unsigned TIW        = (L > 1) ? L - 1 : 1;
  localparam int unsigned RST_LOG2   = (L < 8) ? L : 8;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDOUT  = 4'd1;
  localparam logic [3:0] ST_BF_RA  = 4'd2;
  localparam logic [3:0] ST_BF_RB  = 4'd3;
  localparam logic [3:0] ST_BF_MUL = 4'd4;
  localparam logic [3:0] ST_BF_RND = 4'd5;
  localparam logic [3:0] ST_BF_WA  = 4'd6;
  localparam logic [3:0] ST_BF_WB  = 4'd7;
  localparam logic [3:0] ST_MG_RD  = 4'd8;
  localparam logic [3:0] ST_MG_SQ  = 4'd9;
  localparam logic [3:0] ST_MG_ST  = 4'd10;
  localparam logic [3:0] ST_MG_RT  = 4'd11;

  logic [3:0]          state_q, state_d;
  logic [CFG_BITS-1:0] log2p_q, log2p_d;
  logic [L-1:0]        cnt_q, cnt_d;
  logic [SW-1:0]       stage_q, stage_d;
  logic [L-1:0]        bfk_q, bfk_d;
  logic                last_q, last_d;
  logic [L-1:0]        a_q, a_d, b_q, b_d;
  logic [L-1:0]        magi_q, magi_d;
  logic                any_q, any_d;
  logic [L-1:0]        lim_q, lim_d;
  logic [L-1:0]        rd_idx_q, rd_idx_d;
  logic                rd_err_q, rd_err_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ld;
  logic [L-1:0]        out_idx_q;
  logic [MAG_BITS-1:0] out_mag_q;
  logic                out_err_q;

  logic                in_acc, ld_acc, rd_acc;
  logic [L:0]          n_pts, half_pts;
  logic [L-1:0]        rev_full, rev_addr;
  logic [L-1:0]        half_sz, low, a_nx, b_nx, tw_t, tw_i;
  logic                tw_neg, tw_ld;
  logic signed [TWIDDLE_BITS-1:0] cos_tab [QUARTER+1];
  logic signed [TWIDDLE_BITS-1:0] sin_tab [QUARTER+1];
  logic signed [TWIDDLE_BITS-1:0] tw_c_q, tw_s_q;

  logic                work_we, work_re;
  logic [L-1:0]        work_waddr, work_raddr;
  logic [2*W-1:0]      work_wdata, work_rdata, sum_a, sum_b;
  logic                mag_we, mag_re;
  logic [MAG_BITS-1:0] mag_wdata, mag_rdata;
  bfly_ctl_t           bctl;
  mag_ctl_t            mctl;
  mag_sts_t            msts;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ld_acc     = in_acc && (command_i == CMD_LOAD);
  assign rd_acc     = in_acc && (command_i == CMD_READ);
  assign n_pts      = (L+1)'(1) << log2p_q;
  assign half_pts   = n_pts >> 1;

  // Bit-reversed load address within the current transform length.
  always_comb begin
    for (int i = 0; i < L; i++) begin
      rev_full[i] = cnt_q[L-1-i];
    end
  end
  assign rev_addr = rev_full >> (CFG_BITS'(L) - log2p_q);

  // Butterfly addressing: insert a zero at the stage bit of the counter.
  assign half_sz = L'(1) << stage_q;
  assign low     = bfk_q & (half_sz - L'(1));
  assign a_nx    = ((bfk_q & ~(half_sz - L'(1))) << 1) | low;
  assign b_nx    = a_nx | half_sz;

  // Twiddle index folded into the first quadrant.
  assign tw_t   = low << (SW'(L - 1) - stage_q);
  assign tw_neg = (tw_t > L'(QUARTER));
  assign tw_i   = tw_neg ? (L'(HALF_MAX) - tw_t) : tw_t;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tw
    assign cos_tab[g] = TWIDDLE_BITS'(twiddle_q(g, L, TWIDDLE_BITS, 1'b0));
    assign sin_tab[g] = TWIDDLE_BITS'(twiddle_q(g, L, TWIDDLE_BITS, 1'b1));
  end

  always_ff @(posedge clk_i) begin
    if (tw_ld) begin
      tw_c_q <= tw_neg ? -cos_tab[tw_i[TIW-1:0]] : cos_tab[tw_i[TIW-1:0]];
      tw_s_q <= sin_tab[tw_i[TIW-1:0]];
    end
  end

  // Sequencer for loads, reads, butterflies and the magnitude pass.
  always_comb begin
    state_d     = state_q;
    log2p_d     = log2p_q;
    cnt_d       = cnt_q;
    stage_d     = stage_q;
    bfk_d       = bfk_q;
    last_d      = last_q;
    a_d         = a_q;
    b_d         = b_q;
    magi_d      = magi_q;
    any_d       = any_q;
    lim_d       = lim_q;
    rd_idx_d    = rd_idx_q;
    rd_err_d    = rd_err_q;
    out_valid_d = out_valid_q;
    out_ld      = 1'b0;
    tw_ld       = 1'b0;
    bctl        = '0;
    mctl        = '0;
    work_we     = 1'b0;
    work_waddr  = a_q;
    work_wdata  = sum_a;
    work_re     = 1'b0;
    work_raddr  = a_nx;
    mag_we      = 1'b0;
    mag_re      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (ld_acc) begin
          work_we    = 1'b1;
          work_waddr = rev_addr;
          work_wdata = {W'(sample_i), {W{1'b0}}};
          if ((L+1)'(cnt_q) + (L+1)'(1) == n_pts) begin
            cnt_d   = '0;
            stage_d = '0;
            bfk_d   = '0;
            last_d  = 1'b0;
            state_d = ST_BF_RA;
          end else begin
            cnt_d = cnt_q + L'(1);
          end
        end else if (rd_acc) begin
          mag_re   = 1'b1;
          rd_idx_d = bin_index_i;
          rd_err_d = ((L+1)'(bin_index_i) > half_pts);
          state_d  = ST_RDOUT;
        end
        if (cfg_we_i) begin
          cnt_d = '0;
          if (cfg_wdata_i == '0) begin
            log2p_d = CFG_BITS'(1);
          end else if (cfg_wdata_i > CFG_BITS'(L)) begin
            log2p_d = CFG_BITS'(L);
          end else begin
            log2p_d = cfg_wdata_i;
          end
        end
      end
      ST_RDOUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ld      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_BF_RA: begin
        work_re = 1'b1;
        a_d     = a_nx;
        b_d     = b_nx;
        state_d = ST_BF_RB;
      end
      ST_BF_RB: begin
        work_re    = 1'b1;
        work_raddr = b_q;
        bctl.ld_u  = 1'b1;
        tw_ld      = 1'b1;
        state_d    = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        bctl.mul = 1'b1;
        state_d  = ST_BF_RND;
      end
      ST_BF_RND: begin
        bctl.rnd = 1'b1;
        state_d  = ST_BF_WA;
      end
      ST_BF_WA: begin
        work_we    = 1'b1;
        work_waddr = a_q;
        work_wdata = sum_a;
        if ((L+1)'(bfk_q) + (L+1)'(1) == half_pts) begin
          bfk_d = '0;
          if ((CFG_BITS)'(stage_q) + CFG_BITS'(1) == log2p_q) begin
            last_d = 1'b1;
          end else begin
            stage_d = stage_q + SW'(1);
          end
        end else begin
          bfk_d = bfk_q + L'(1);
        end
        state_d = ST_BF_WB;
      end
      ST_BF_WB: begin
        work_we    = 1'b1;
        work_waddr = b_q;
        work_wdata = sum_b;
        if (last_q) begin
          magi_d  = '0;
          state_d = ST_MG_RD;
        end else begin
          work_re = 1'b1;
          a_d     = a_nx;
          b_d     = b_nx;
          state_d = ST_BF_RB;
        end
      end
      ST_MG_RD: begin
        work_re    = 1'b1;
        work_raddr = magi_q;
        state_d    = ST_MG_SQ;
      end
      ST_MG_SQ: begin
        mctl.sq = 1'b1;
        state_d = ST_MG_ST;
      end
      ST_MG_ST: begin
        mctl.start = 1'b1;
        state_d    = ST_MG_RT;
      end
      ST_MG_RT: begin
        if (msts.done) begin
          mag_we = 1'b1;
          if ((L+1)'(magi_q) == half_pts) begin
            any_d   = 1'b1;
            lim_d   = half_pts[L-1:0];
            state_d = ST_IDLE;
          end else begin
            magi_d  = magi_q + L'(1);
            state_d = ST_MG_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      log2p_q     <= CFG_BITS'(RST_LOG2);
      cnt_q       <= '0;
      stage_q     <= '0;
      bfk_q       <= '0;
      last_q      <= 1'b0;
      magi_q      <= '0;
      any_q       <= 1'b0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      log2p_q     <= log2p_d;
      cnt_q       <= cnt_d;
      stage_q     <= stage_d;
      bfk_q       <= bfk_d;
      last_q      <= last_d;
      magi_q      <= magi_d;
      any_q       <= any_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Addresses, read request and result payload.
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    rd_idx_q <= rd_idx_d;
    rd_err_q <= rd_err_d;
    if (out_ld) begin
      out_idx_q <= rd_idx_q;
      out_err_q <= rd_err_q;
      if (rd_err_q || !any_q || (rd_idx_q > lim_q)) begin
        out_mag_q <= '0;
      end else begin
        out_mag_q <= mag_rdata;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_index_o  = out_idx_q;
  assign magnitude_o   = out_mag_q;
  assign index_error_o = out_err_q;

  // Work memory: real part over imaginary part.
  fmsu_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_POINTS)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .re_i    (work_re),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  // Magnitude store for bins 0..N/2.
  fmsu_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (HALF_MAX + 1)
  ) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (mag_we),
    .waddr_i (magi_q),
    .wdata_i (mag_wdata),
    .re_i    (mag_re),
    .raddr_i (bin_index_i),
    .rdata_o (mag_rdata)
  );

  fmsu_bfly #(
    .W_BITS  (W),
    .TW_BITS (TWIDDLE_BITS)
  ) u_bfly (
    .clk_i   (clk_i),
    .ctl_i   (bctl),
    .rdata_i (work_rdata),
    .tw_c_i  (tw_c_q),
    .tw_s_i  (tw_s_q),
    .sum_a_o (sum_a),
    .sum_b_o (sum_b)
  );

  fmsu_mag #(
    .W_BITS (W)
  ) u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .data_i (work_rdata),
    .sts_o  (msts),
    .mag_o  (mag_wdata)
  );

  // The next butterfly's first read never hits the entry being written.
  `FMSU_ASSERT_IMP(a_no_rw_overlap, clk_i, rst_ni, work_we && work_re, work_waddr != work_raddr)
  // The two entries of a butterfly differ exactly in the stage bit.
  `FMSU_ASSERT_IMP(a_bfly_pair, clk_i, rst_ni, state_q == ST_BF_WA, ((a_q & half_sz) == '0) && (b_q == (a_q | half_sz)))
  // The magnitude pass stays within bins 0..N/2.
  `FMSU_ASSERT_IMP(a_mag_range, clk_i, rst_ni, state_q == ST_MG_RT, (L+1)'(magi_q) <= half_pts)
  // A result only appears after a read beat has fetched its bin.
  `FMSU_ASSERT_IMP(a_result_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_RDOUT)

endmodule
